FILE: src/blr_pkg.sv
package blr_pkg;

	// Screen rotation codes, as held in the rotation register
	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_90   = 2'd1,
		ROT_180  = 2'd2,
		ROT_270  = 2'd3
	} rot_t;

	localparam int unsigned ROT_BITS = 2;

	// Input action codes
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

endpackage

FILE: src/bresenham_line_rasterizer_top.sv
// Bresenham line rasterizer. A start item (action 0) loads a line between two signed
// endpoints plus a colour and yields its first pixel; each advance item (action 1) yields
// the next pixel along the major axis, with last_pixel set on the final one. An advance
// while no line is active yields a result with pixel_valid low and every field zero. Each
// pixel is rotated as the rotation register selects and clipped to the screen; on_screen
// reports whether it was drawn. One item is accepted per clock and each item gives
// exactly one result: the first register holds the stepped, unrotated pixel and the
// second holds the rotated, clipped result, so one item per clock is sustained whenever
// the result side is not stalled. The rotation register is written through its own
// valid/ready port, which is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce.
module bresenham_line_rasterizer_top #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240,
	parameter int COORD_BITS    = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [blr_pkg::ROT_BITS-1:0]        rotation,
	// input items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	input  logic [15:0]                         color,
	// result items
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                pixel_valid,
	output logic                                on_screen,
	output logic [(SCREEN_WIDTH  > 1 ? $clog2(SCREEN_WIDTH)  : 1)-1:0] pixel_x,
	output logic [(SCREEN_HEIGHT > 1 ? $clog2(SCREEN_HEIGHT) : 1)-1:0] pixel_y,
	output logic [15:0]                         pixel_color,
	output logic                                last_pixel
);

	import blr_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int XW = SCREEN_WIDTH  > 1 ? $clog2(SCREEN_WIDTH)  : 1;
	localparam int YW = SCREEN_HEIGHT > 1 ? $clog2(SCREEN_HEIGHT) : 1;
	// rotated coordinate width: room for screen limits and a sign-extended coordinate
	localparam int RW = (C > 12 ? C : 12) + 2;

	localparam logic signed [RW-1:0] W_MAX = RW'(SCREEN_WIDTH - 1);
	localparam logic signed [RW-1:0] H_MAX = RW'(SCREEN_HEIGHT - 1);
	localparam logic signed [RW-1:0] W_LIM = RW'(SCREEN_WIDTH);
	localparam logic signed [RW-1:0] H_LIM = RW'(SCREEN_HEIGHT);

	// line state
	rot_t                 rotation_q;
	logic                 active_q;
	logic                 steep_q;
	logic signed [C-1:0]  major_pos_q;
	logic signed [C-1:0]  major_end_q;
	logic signed [C-1:0]  minor_pos_q;
	logic signed [C:0]    err_q;
	logic [C-1:0]         major_delta_q;
	logic [C-1:0]         minor_delta_q;
	logic                 minor_neg_q;
	logic [15:0]          color_q;

	// stage 1: stepped pixel before rotation
	logic                 valid_s1;
	logic                 pv_s1;
	logic signed [C-1:0]  px_s1;
	logic signed [C-1:0]  py_s1;
	logic                 last_s1;
	logic [15:0]          color_s1;

	// stage 2: result register
	logic                 valid_s2;
	logic                 pv_s2;
	logic                 on_s2;
	logic [XW-1:0]        x_s2;
	logic [YW-1:0]        y_s2;
	logic [15:0]          color_s2;
	logic                 last_s2;

	// handshake
	logic en_s2, en_s1, accept;

	assign cfg_ready = 1'b1;
	assign en_s2     = !valid_s2 || !out_stall;
	assign en_s1     = !valid_s1 || en_s2;
	assign in_stall  = !en_s1;
	assign accept    = in_valid && en_s1;

	// start set-up
	logic signed [C:0]    dx_w, dy_w, dmaj_w, dmin_w;
	logic [C-1:0]         adx_w, ady_w, amin_w;
	logic                 steep_w;
	logic signed [C-1:0]  a0_w, b0_w, a1_w, b1_w;
	logic signed [C-1:0]  sa0_w, sb0_w, sa1_w, sb1_w;

	always_comb begin
		dx_w    = {end_x[C-1], end_x} - {start_x[C-1], start_x};
		dy_w    = {end_y[C-1], end_y} - {start_y[C-1], start_y};
		adx_w   = dx_w[C] ? C'(-dx_w) : dx_w[C-1:0];
		ady_w   = dy_w[C] ? C'(-dy_w) : dy_w[C-1:0];
		steep_w = ady_w > adx_w;
		if (steep_w) begin
			a0_w = start_y; b0_w = start_x; a1_w = end_y; b1_w = end_x;
		end else begin
			a0_w = start_x; b0_w = start_y; a1_w = end_x; b1_w = end_y;
		end
		// order endpoints along the major axis
		if (a0_w > a1_w) begin
			sa0_w = a1_w; sb0_w = b1_w; sa1_w = a0_w; sb1_w = b0_w;
		end else begin
			sa0_w = a0_w; sb0_w = b0_w; sa1_w = a1_w; sb1_w = b1_w;
		end
		dmaj_w = {sa1_w[C-1], sa1_w} - {sa0_w[C-1], sa0_w};
		dmin_w = {sb1_w[C-1], sb1_w} - {sb0_w[C-1], sb0_w};
		amin_w = dmin_w[C] ? C'(-dmin_w) : dmin_w[C-1:0];
	end

	// advance step
	logic signed [C:0]    err_sub_w, err_add_w;
	logic signed [C-1:0]  minor_step_w, major_inc_w;
	logic                 adv_last_w;

	always_comb begin
		err_sub_w    = err_q - $signed({1'b0, minor_delta_q});
		err_add_w    = err_sub_w + $signed({1'b0, major_delta_q});
		minor_step_w = minor_neg_q ? minor_pos_q - C'(1) : minor_pos_q + C'(1);
		major_inc_w  = major_pos_q + C'(1);
		adv_last_w   = major_inc_w >= major_end_q;
	end

	// line state and stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q    <= ROT_NONE;
			active_q      <= 1'b0;
			steep_q       <= 1'b0;
			major_pos_q   <= '0;
			major_end_q   <= '0;
			minor_pos_q   <= '0;
			err_q         <= '0;
			major_delta_q <= '0;
			minor_delta_q <= '0;
			minor_neg_q   <= 1'b0;
			color_q       <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rotation_q <= rot_t'(rotation);
			end
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				if (action == ACT_START) begin
					steep_q       <= steep_w;
					major_pos_q   <= sa0_w;
					major_end_q   <= sa1_w;
					minor_pos_q   <= sb0_w;
					major_delta_q <= dmaj_w[C-1:0];
					minor_delta_q <= amin_w;
					err_q         <= $signed({2'b00, dmaj_w[C-1:1]});
					minor_neg_q   <= !(sb0_w < sb1_w);
					color_q       <= color;
					active_q      <= sa0_w != sa1_w;
				end else if (active_q) begin
					if (err_sub_w < 0) begin
						minor_pos_q <= minor_step_w;
						err_q       <= err_add_w;
					end else begin
						err_q <= err_sub_w;
					end
					major_pos_q <= major_inc_w;
					active_q    <= !adv_last_w;
				end
			end
		end
	end

	// stage 1 payload: unrotated pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			if (action == ACT_START) begin
				pv_s1    <= 1'b1;
				px_s1    <= steep_w ? sb0_w : sa0_w;
				py_s1    <= steep_w ? sa0_w : sb0_w;
				last_s1  <= sa0_w == sa1_w;
				color_s1 <= color;
			end else if (active_q) begin
				pv_s1    <= 1'b1;
				px_s1    <= steep_q ? (err_sub_w < 0 ? minor_step_w : minor_pos_q)
				                    : major_inc_w;
				py_s1    <= steep_q ? major_inc_w
				                    : (err_sub_w < 0 ? minor_step_w : minor_pos_q);
				last_s1  <= adv_last_w;
				color_s1 <= color_q;
			end else begin
				pv_s1    <= 1'b0;
				px_s1    <= '0;
				py_s1    <= '0;
				last_s1  <= 1'b0;
				color_s1 <= '0;
			end
		end
	end

	// rotation and clipping
	logic signed [RW-1:0] px_e, py_e, nx_w, ny_w;
	logic                 on_w;

	always_comb begin
		px_e = {{(RW-C){px_s1[C-1]}}, px_s1};
		py_e = {{(RW-C){py_s1[C-1]}}, py_s1};
		unique case (rotation_q)
			ROT_90: begin
				nx_w = W_MAX - py_e;
				ny_w = px_e;
			end
			ROT_180: begin
				nx_w = W_MAX - px_e;
				ny_w = H_MAX - py_e;
			end
			ROT_270: begin
				nx_w = py_e;
				ny_w = H_MAX - px_e;
			end
			default: begin
				nx_w = px_e;
				ny_w = py_e;
			end
		endcase
		on_w = pv_s1 && nx_w >= 0 && nx_w < W_LIM && ny_w >= 0 && ny_w < H_LIM;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			pv_s2    <= pv_s1;
			on_s2    <= on_w;
			x_s2     <= on_w ? nx_w[XW-1:0] : '0;
			y_s2     <= on_w ? ny_w[YW-1:0] : '0;
			color_s2 <= color_s1;
			last_s2  <= last_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_valid = pv_s2;
	assign on_screen   = on_s2;
	assign pixel_x     = x_s2;
	assign pixel_y     = y_s2;
	assign pixel_color = color_s2;
	assign last_pixel  = last_s2;

endmodule

FILE: bench/bresenham_line_rasterizer_top_tb.sv
`timescale 1ns / 100ps

module bresenham_line_rasterizer_top_tb;
	import blr_pkg::*;

	localparam int SCREEN_W   = 320;
	localparam int SCREEN_H   = 240;
	localparam int CRD_BITS   = 12;
	localparam int X_BITS     = $clog2(SCREEN_W);
	localparam int Y_BITS     = $clog2(SCREEN_H);
	localparam int STALL_PCT  = 12;
	localparam int IDLE_LIMIT = 5000;

	// One input item as driven on the payload ports
	typedef struct {
		logic                       act;
		logic signed [CRD_BITS-1:0] sx;
		logic signed [CRD_BITS-1:0] sy;
		logic signed [CRD_BITS-1:0] ex;
		logic signed [CRD_BITS-1:0] ey;
		logic [15:0]                col;
	} line_item_t;

	// One result item
	typedef struct {
		logic              pv;
		logic              on;
		logic [X_BITS-1:0] x;
		logic [Y_BITS-1:0] y;
		logic [15:0]       col;
		logic              last;
	} pixel_t;

	// Line stepper and rotation/clip predictor with a queue of pending pixels
	class pixel_scoreboard;
		rot_t                       rot = ROT_NONE;
		bit                         active = 0;
		bit                         steep = 0;
		bit                         step_neg = 0;
		logic signed [CRD_BITS-1:0] major_pos = '0;
		logic signed [CRD_BITS-1:0] major_end = '0;
		logic signed [CRD_BITS-1:0] minor_pos = '0;
		logic signed [CRD_BITS:0]   err = '0;
		logic [CRD_BITS-1:0]        major_delta = '0;
		logic [CRD_BITS-1:0]        minor_delta = '0;
		logic [15:0]                line_col = '0;
		pixel_t                     pending[$];
		int                         errors = 0;

		function void set_rotation(rot_t r);
			rot = r;
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		// Rotate the current position and clip it to the screen
		function pixel_t place(bit last);
			int     px, py, nx, ny;
			bit     on;
			pixel_t p;
			px = steep ? minor_pos : major_pos;
			py = steep ? major_pos : minor_pos;
			case (rot)
				ROT_90: begin
					nx = SCREEN_W - 1 - py;
					ny = px;
				end
				ROT_180: begin
					nx = SCREEN_W - 1 - px;
					ny = SCREEN_H - 1 - py;
				end
				ROT_270: begin
					nx = py;
					ny = SCREEN_H - 1 - px;
				end
				default: begin
					nx = px;
					ny = py;
				end
			endcase
			on = nx >= 0 && nx < SCREEN_W && ny >= 0 && ny < SCREEN_H;
			p.pv   = 1'b1;
			p.on   = on;
			p.x    = on ? nx[X_BITS-1:0] : '0;
			p.y    = on ? ny[Y_BITS-1:0] : '0;
			p.col  = line_col;
			p.last = last;
			return p;
		endfunction

		function void note_item(line_item_t it);
			int     x0, y0, x1, y1, adx, ady, a0, b0, a1, b1, t, e, md, mj, mp;
			bit     last;
			pixel_t idle_px;
			if (it.act == ACT_START) begin
				x0 = it.sx;
				y0 = it.sy;
				x1 = it.ex;
				y1 = it.ey;
				adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
				ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
				steep = ady > adx;
				if (steep) begin
					a0 = y0; b0 = x0; a1 = y1; b1 = x1;
				end else begin
					a0 = x0; b0 = y0; a1 = x1; b1 = y1;
				end
				// order the endpoints along the major axis
				if (a0 > a1) begin
					t = a0; a0 = a1; a1 = t;
					t = b0; b0 = b1; b1 = t;
				end
				major_pos   = CRD_BITS'(a0);
				major_end   = CRD_BITS'(a1);
				minor_pos   = CRD_BITS'(b0);
				major_delta = CRD_BITS'(a1 - a0);
				minor_delta = CRD_BITS'((b1 >= b0) ? b1 - b0 : b0 - b1);
				err         = (CRD_BITS+1)'((a1 - a0) / 2);
				step_neg    = !(b0 < b1);
				line_col    = it.col;
				last        = (a0 == a1);
				active      = !last;
				pending.push_back(place(last));
			end else if (!active) begin
				idle_px = '{pv: 1'b0, on: 1'b0, x: '0, y: '0, col: '0, last: 1'b0};
				pending.push_back(idle_px);
			end else begin
				// error update, minor step on underflow
				e  = err;
				md = minor_delta;
				mj = major_delta;
				e  = e - md;
				if (e < 0) begin
					mp = minor_pos;
					mp = mp + (step_neg ? -1 : 1);
					minor_pos = CRD_BITS'(mp);
					e = e + mj;
				end
				err = (CRD_BITS+1)'(e);
				mp = major_pos;
				major_pos = CRD_BITS'(mp + 1);
				last = (major_pos >= major_end);
				active = !last;
				pending.push_back(place(last));
			end
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending.size() == 0) begin
				$error("result item with no pixel pending");
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("pixel_valid", want.pv, got.pv);
			compare_field("on_screen", want.on, got.on);
			compare_field("pixel_x", want.x, got.x);
			compare_field("pixel_y", want.y, got.y);
			compare_field("pixel_color", want.col, got.col);
			compare_field("last_pixel", want.last, got.last);
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [ROT_BITS-1:0]        rotation;
	logic                       in_valid;
	logic                       in_stall;
	logic                       action;
	logic signed [CRD_BITS-1:0] start_x;
	logic signed [CRD_BITS-1:0] start_y;
	logic signed [CRD_BITS-1:0] end_x;
	logic signed [CRD_BITS-1:0] end_y;
	logic [15:0]                color;
	logic                       out_valid;
	logic                       out_stall;
	logic                       pixel_valid;
	logic                       on_screen;
	logic [X_BITS-1:0]          pixel_x;
	logic [Y_BITS-1:0]          pixel_y;
	logic [15:0]                pixel_color;
	logic                       last_pixel;

	pixel_scoreboard sb = new;
	bit              quiet = 1'b0;
	int              items_sent = 0;
	int              idle_cycles = 0;

	bresenham_line_rasterizer_top #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H),
		.COORD_BITS   (CRD_BITS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.rotation   (rotation),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.color      (color),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_valid(pixel_valid),
		.on_screen  (on_screen),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
	end

	// Result checking and watchdog
	always @(posedge clk) begin : monitor
		pixel_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{pv: pixel_valid, on: on_screen, x: pixel_x, y: pixel_y,
					col: pixel_color, last: last_pixel};
				sb.check_pixel(got);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Drive one input item, with random gaps before it
	task automatic send_item(input line_item_t it);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= it.act;
		start_x  <= it.sx;
		start_y  <= it.sy;
		end_x    <= it.ex;
		end_y    <= it.ey;
		color    <= it.col;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(it);
		items_sent++;
	endtask

	function automatic line_item_t random_item(logic act);
		line_item_t it;
		it.act = act;
		it.sx  = CRD_BITS'($urandom);
		it.sy  = CRD_BITS'($urandom);
		it.ex  = CRD_BITS'($urandom);
		it.ey  = CRD_BITS'($urandom);
		it.col = 16'($urandom);
		return it;
	endfunction

	// Start a line and follow it with a number of advances carrying junk payloads
	task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
		input logic [15:0] col, input int n_adv);
		line_item_t it;
		it.act = ACT_START;
		it.sx  = CRD_BITS'(x0);
		it.sy  = CRD_BITS'(y0);
		it.ex  = CRD_BITS'(x1);
		it.ey  = CRD_BITS'(y1);
		it.col = col;
		send_item(it);
		repeat (n_adv) send_item(random_item(ACT_ADVANCE));
	endtask

	// Stop sending and wait until every pixel has come out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rotation(input rot_t r);
		@(negedge clk);
		cfg_valid <= 1'b1;
		rotation  <= r;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_rotation(r);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Coordinate mostly around the screen, sometimes anywhere in range
	function automatic int pick_coord();
		int c;
		if ($urandom_range(99) < 70) begin
			c = $urandom_range(0, 420);
			c = c - 50;
		end else begin
			c = $urandom_range(0, 4095);
			c = c - 2048;
		end
		return c;
	endfunction

	function automatic int near(int c, int d);
		int v;
		v = $urandom_range(0, 2 * d);
		v = c + v - d;
		if (v < -2048) v = -2048;
		if (v > 2047) v = 2047;
		return v;
	endfunction

	// Mostly whole lines with random content, some cut short or run past their end, some noise
	task automatic random_phase(input int n_items);
		int first, x0, y0, x1, y1, d, span, n;
		first = items_sent;
		while (items_sent - first < n_items) begin
			if ($urandom_range(99) < 85) begin
				d  = ($urandom_range(99) < 95) ? $urandom_range(0, 30) : $urandom_range(0, 300);
				x0 = pick_coord();
				y0 = pick_coord();
				x1 = near(x0, d);
				y1 = near(y0, d);
				span = (x1 > x0 ? x1 - x0 : x0 - x1);
				if ((y1 > y0 ? y1 - y0 : y0 - y1) > span)
					span = (y1 > y0 ? y1 - y0 : y0 - y1);
				n = span;
				if ($urandom_range(9) == 0) n = $urandom_range(0, span);
				if ($urandom_range(19) == 0) n = n + $urandom_range(1, 3);
				draw_line(x0, y0, x1, y1, 16'($urandom), n);
			end else begin
				send_item(random_item(1'($urandom_range(1))));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		rotation  = ROT_NONE;
		in_valid  = 1'b0;
		action    = ACT_START;
		start_x   = '0;
		start_y   = '0;
		end_x     = '0;
		end_y     = '0;
		color     = '0;
		out_stall = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items
		write_rotation(ROT_NONE);
		send_item(random_item(ACT_ADVANCE));              // advance with no line
		draw_line(0, 0, 0, 0, 16'h1234, 1);              // single point, then idle advance
		draw_line(10, 20, 15, 22, 16'hA5A5, 5);
		draw_line(5, 10, 3, 6, 16'h5A5A, 4);             // steep, minor coordinate steps up
		draw_line(100, 50, 103, 50, 16'h0F0F, 3);        // minor coordinate constant
		draw_line(-2048, -2048, 2047, 2047, 16'hFFFF, 2);
		draw_line(2047, -2048, -2048, 2047, 16'h0000, 1); // restart drops the old line
		draw_line(319, 239, 321, 241, 16'h8001, 2);      // leaves the screen
		settle();

		// Random items under each rotation
		write_rotation(ROT_90);
		random_phase(200);
		settle();
		random_phase(200);
		settle();
		write_rotation(ROT_180);
		quiet = 1'b1;
		random_phase(400);
		settle();
		quiet = 1'b0;
		write_rotation(ROT_270);
		random_phase(400);
		settle();
		write_rotation(ROT_NONE);
		random_phase(400);
		settle();
		write_rotation(ROT_90);
		random_phase(200);
		settle();
		write_rotation(ROT_270);
		random_phase(200);
		settle();

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
